// ----- sv/npsd_pkg.sv -----
// ----------------------------------------------------------------------------
// npsd_pkg: shared types and constants for the nearest point search
// Holds the result field widths, status and command codes, the controller
// states and the control bundle that moves along the distance cells.
// ----------------------------------------------------------------------------
package npsd_pkg;

  localparam int N_REF_DEF      = 1024;
  localparam int COORD_BITS_DEF = 16;

  localparam int OUT_IDX_W   = 10;
  localparam int OUT_DIST_W  = 34;
  localparam int STATUS_W    = 2;
  localparam int OUT_FIELD_W = OUT_IDX_W + OUT_DIST_W + STATUS_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_DONE
  } npsd_state_t;

  // Control that travels with each reference point through the cells.
  typedef struct packed {
    logic valid;
    logic last;
  } npsd_ctrl_t;

endpackage

// ----- sv/npsd_axis_cell.sv -----
// ----------------------------------------------------------------------------
// npsd_axis_cell: one distance cell of the chain
// Holds one coordinate of the query point, adds the squared difference on its
// axis to the partial distance and hands the point on to the next cell.
// ----------------------------------------------------------------------------
module npsd_axis_cell #(
  parameter int COORD_BITS = npsd_pkg::COORD_BITS_DEF,
  parameter int IDX_W      = 10,
  parameter int AXIS       = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_load,
  input  logic [3*COORD_BITS-1:0]     q_point,
  input  npsd_pkg::npsd_ctrl_t        in_ctrl,
  input  logic [IDX_W-1:0]            in_idx,
  input  logic [3*COORD_BITS-1:0]     in_point,
  input  logic [2*COORD_BITS+1:0]     in_sum,
  output npsd_pkg::npsd_ctrl_t        out_ctrl,
  output logic [IDX_W-1:0]            out_idx,
  output logic [3*COORD_BITS-1:0]     out_point,
  output logic [2*COORD_BITS+1:0]     out_sum
);
  import npsd_pkg::*;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int DIST_W = 2 * COORD_BITS + 2;

  logic signed [COORD_BITS-1:0] q_coord;
  logic signed [COORD_BITS-1:0] ref_coord;
  logic signed [DIFF_W-1:0]     diff;
  logic signed [DIST_W-1:0]     sq;
  npsd_ctrl_t                   ctrl1;
  logic [IDX_W-1:0]             idx1;
  logic [3*COORD_BITS-1:0]      point1;
  logic [DIST_W-1:0]            sum1;

  assign ref_coord = in_point[AXIS*COORD_BITS +: COORD_BITS];
  assign sq        = diff * diff;

  always_ff @(posedge clk) begin
    if (q_load) begin
      q_coord <= q_point[AXIS*COORD_BITS +: COORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1    <= '0;
      out_ctrl <= '0;
    end else begin
      ctrl1    <= in_ctrl;
      out_ctrl <= ctrl1;
    end
  end

  always_ff @(posedge clk) begin
    diff      <= DIFF_W'(ref_coord) - DIFF_W'(q_coord);
    idx1      <= in_idx;
    point1    <= in_point;
    sum1      <= in_sum;
    out_idx   <= idx1;
    out_point <= point1;
    out_sum   <= sum1 + $unsigned(sq);
  end

endmodule

// ----- sv/npsd_min_track.sv -----
// ----------------------------------------------------------------------------
// npsd_min_track: running minimum at the end of the cell chain
// Keeps the closest point seen so far in a scan and reports it after the
// last point of the scan has passed.
// ----------------------------------------------------------------------------
module npsd_min_track #(
  parameter int COORD_BITS = npsd_pkg::COORD_BITS_DEF,
  parameter int IDX_W      = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  npsd_pkg::npsd_ctrl_t        in_ctrl,
  input  logic [IDX_W-1:0]            in_idx,
  input  logic [2*COORD_BITS+1:0]     in_sum,
  output logic                        res_valid,
  output logic [IDX_W-1:0]            res_idx,
  output logic [2*COORD_BITS+1:0]     res_dist
);
  import npsd_pkg::*;

  localparam int DIST_W = 2 * COORD_BITS + 2;

  logic [IDX_W-1:0]  best_idx;
  logic [DIST_W-1:0] best_dist;
  logic              take;

  // The first point of a scan always replaces the old minimum; a later one
  // only on a strictly smaller distance, so the lowest index wins a tie.
  assign take = (in_idx == '0) || (in_sum < best_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= in_ctrl.valid && in_ctrl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ctrl.valid && take) begin
      best_idx  <= in_idx;
      best_dist <= in_sum;
    end
    res_idx  <= take ? in_idx : best_idx;
    res_dist <= take ? in_sum : best_dist;
  end

endmodule

// ----- sv/nearest_point_search_3d_top.sv -----
// ----------------------------------------------------------------------------
// nearest_point_search_3d_top: brute-force nearest point search in 3D
// A load request appends one point to the store unless it is full; a query
// request returns the index and squared distance of the closest stored point.
// ----------------------------------------------------------------------------
// A load goes from acceptance through the done state to the output register.
// A query reads the point store through its single read port, one point per
// cycle, and passes through taking the request, the scan itself with its
// memory reads, the chain of three distance cells, the minimum tracker and
// the controller. One request is worked on at a time; a finished result waits
// in the output register while the next request is taken. Only points that
// have been loaded are ever used, so the store needs no clearing after reset.
module nearest_point_search_3d_top #(
  parameter int N_REF      = npsd_pkg::N_REF_DEF,
  parameter int COORD_BITS = npsd_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // cmd, coord_x, coord_y, coord_z (lowest bit up), zero padded to bytes
  input  logic [((3*COORD_BITS+8)/8)*8-1:0]      s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // nearest_index, nearest_distance, status (lowest bit up), zero padded
  output logic [npsd_pkg::OUT_TDATA_W-1:0]       m_tdata
);
  import npsd_pkg::*;

  localparam int IDX_W   = (N_REF > 1) ? $clog2(N_REF) : 1;
  localparam int CNT_W   = $clog2(N_REF + 1);
  localparam int POINT_W = 3 * COORD_BITS;
  localparam int DIST_W  = 2 * COORD_BITS + 2;

  npsd_state_t state, state_next;

  logic [POINT_W-1:0] mem [N_REF];

  logic               cmd;
  logic [POINT_W-1:0] in_point;
  logic               accept;
  logic               full;
  logic               issue;
  logic               issue_last;
  logic               out_free;
  logic [CNT_W-1:0]   count_m1;

  logic [CNT_W-1:0]   point_count;
  logic [IDX_W-1:0]   scan_idx;

  npsd_ctrl_t         rd_ctrl;
  logic [IDX_W-1:0]   rd_idx;
  logic [POINT_W-1:0] rd_data;

  npsd_ctrl_t         chain_ctrl  [4];
  logic [IDX_W-1:0]   chain_idx   [4];
  logic [POINT_W-1:0] chain_point [4];
  logic [DIST_W-1:0]  chain_sum   [4];

  logic               res_valid;
  logic [IDX_W-1:0]   res_idx;
  logic [DIST_W-1:0]  res_dist;

  logic [IDX_W-1:0]   pend_idx;
  logic [DIST_W-1:0]  pend_dist;
  logic [STATUS_W-1:0] pend_status;

  logic [OUT_IDX_W+IDX_W-1:0]   idx_ext;
  logic [OUT_DIST_W+DIST_W-1:0] dist_ext;

  assign cmd        = s_tdata[0];
  assign in_point   = s_tdata[1 +: POINT_W];
  assign accept     = s_tvalid && s_tready;
  assign full       = (point_count == CNT_W'(N_REF));
  assign count_m1   = point_count - 1'b1;
  assign issue_last = (scan_idx == count_m1[IDX_W-1:0]);
  assign out_free   = !m_tvalid || m_tready;
  assign idx_ext    = {{OUT_IDX_W{1'b0}}, pend_idx};
  assign dist_ext   = {{OUT_DIST_W{1'b0}}, pend_dist};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    issue      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (cmd == CMD_QUERY && point_count != '0) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        issue = 1'b1;
        if (issue_last) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (res_valid) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (accept && cmd == CMD_LOAD && !full) begin
      point_count <= point_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scan_idx <= '0;
    end else if (issue) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

  // Point store: one write port for loads, one registered read port for scans.
  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_LOAD && !full) begin
      mem[point_count[IDX_W-1:0]] <= in_point;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[scan_idx];
    rd_idx  <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ctrl <= '0;
    end else begin
      rd_ctrl.valid <= issue;
      rd_ctrl.last  <= issue_last;
    end
  end

  assign chain_ctrl[0]  = rd_ctrl;
  assign chain_idx[0]   = rd_idx;
  assign chain_point[0] = rd_data;
  assign chain_sum[0]   = '0;

  for (genvar a = 0; a < 3; a++) begin : g_cell
    npsd_axis_cell #(
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W),
      .AXIS       (a)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .q_load    (accept),
      .q_point   (in_point),
      .in_ctrl   (chain_ctrl[a]),
      .in_idx    (chain_idx[a]),
      .in_point  (chain_point[a]),
      .in_sum    (chain_sum[a]),
      .out_ctrl  (chain_ctrl[a+1]),
      .out_idx   (chain_idx[a+1]),
      .out_point (chain_point[a+1]),
      .out_sum   (chain_sum[a+1])
    );
  end

  npsd_min_track #(
    .COORD_BITS (COORD_BITS),
    .IDX_W      (IDX_W)
  ) u_min_track (
    .clk       (clk),
    .rst       (rst),
    .in_ctrl   (chain_ctrl[3]),
    .in_idx    (chain_idx[3]),
    .in_sum    (chain_sum[3]),
    .res_valid (res_valid),
    .res_idx   (res_idx),
    .res_dist  (res_dist)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_idx  <= '0;
      pend_dist <= '0;
      if (cmd == CMD_LOAD) begin
        pend_status <= full ? STATUS_FULL : STATUS_OK;
      end else if (point_count == '0) begin
        pend_status <= STATUS_EMPTY;
      end else begin
        pend_status <= STATUS_OK;
      end
    end else if (state == ST_WAIT && res_valid) begin
      pend_idx    <= res_idx;
      pend_dist   <= res_dist;
      pend_status <= STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, pend_status, dist_ext[OUT_DIST_W-1:0],
                  idx_ext[OUT_IDX_W-1:0]};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CNT_W'(N_REF))
    else $error("point count exceeds the store depth");

  a_result_in_wait: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> state == ST_WAIT)
    else $error("scan result arrived outside the wait state");

  a_query_scans: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_QUERY && point_count != '0) |=> state == ST_SCAN)
    else $error("query on a filled store did not start a scan");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (rd_ctrl.valid && rd_ctrl.last) |-> !issue)
    else $error("read issued after the last point of a scan");

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for nearest_point_search_3d_top
// Load and query requests go in through the slave stream. Each accepted
// request is run through a local copy of the point store, and the result it
// predicts is queued. Every result taken from the master stream must match the
// oldest queued prediction in index, distance and status.
// ----------------------------------------------------------------------------
module tb_top;
  import npsd_pkg::*;

  localparam int COORD_W     = COORD_BITS_DEF;
  localparam int STORE_DEPTH = N_REF_DEF;
  localparam int IN_W        = ((3*COORD_W+8)/8)*8;
  localparam int IDLE_PCT    = 13;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Field order matches m_tdata from the lowest bit up.
  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [OUT_DIST_W-1:0] distance;
    logic [OUT_IDX_W-1:0]  idx;
  } result_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_W-1:0]        s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // Local copy of the point store.
  coord_t      pts_x [STORE_DEPTH];
  coord_t      pts_y [STORE_DEPTH];
  coord_t      pts_z [STORE_DEPTH];
  int unsigned pts_count = 0;

  result_t pending_results[$];
  int      failures    = 0;
  int      hold_cycles = 0;
  bit      calm        = 1'b0;

  nearest_point_search_3d_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic longint unsigned dist_to_stored(coord_t x, coord_t y, coord_t z, int k);
    longint dx;
    longint dy;
    longint dz;
    dx = longint'(x) - longint'(pts_x[k]);
    dy = longint'(y) - longint'(pts_y[k]);
    dz = longint'(z) - longint'(pts_z[k]);
    return longint'(dx*dx + dy*dy + dz*dz);
  endfunction

  // Applies one request to the local store and returns the result it gives.
  function automatic result_t nearest_result(logic cmd, coord_t x, coord_t y, coord_t z);
    result_t          r;
    longint unsigned  best;
    longint unsigned  d;
    int unsigned      best_k;
    r      = '0;
    best_k = 0;
    if (cmd == CMD_LOAD) begin
      if (pts_count < STORE_DEPTH) begin
        pts_x[pts_count] = x;
        pts_y[pts_count] = y;
        pts_z[pts_count] = z;
        pts_count++;
      end else begin
        r.status = STATUS_FULL;
      end
    end else if (pts_count == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      best = dist_to_stored(x, y, z, 0);
      for (int k = 1; k < pts_count; k++) begin
        d = dist_to_stored(x, y, z, k);
        // Strict compare keeps the lowest index on a tie.
        if (d < best) begin
          best   = d;
          best_k = k;
        end
      end
      r.idx      = best_k[OUT_IDX_W-1:0];
      r.distance = best[OUT_DIST_W-1:0];
    end
    return r;
  endfunction

  function automatic coord_t rand_coord();
    return coord_t'($urandom_range(65535));
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(3))
      0: return coord_t'(-32768);
      1: return coord_t'(32767);
      2: return coord_t'(0);
      default: return coord_t'(-1);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(logic cmd, coord_t x, coord_t y, coord_t z);
    logic [IN_W-1:0] word;
    word = '0;
    word[0]                     = cmd;
    word[COORD_W:1]             = x;
    word[2*COORD_W:COORD_W+1]   = y;
    word[3*COORD_W:2*COORD_W+1] = z;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = word;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(nearest_result(cmd, x, y, z));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pick_stored(output coord_t x, output coord_t y, output coord_t z);
    int unsigned k;
    k = $urandom_range(pts_count - 1);
    x = pts_x[k];
    y = pts_y[k];
    z = pts_z[k];
  endtask

  task automatic test_empty_store();
    send_request(CMD_QUERY, coord_t'(0), coord_t'(0), coord_t'(0));
    send_request(CMD_QUERY, coord_t'(-1), coord_t'(-32768), coord_t'(32767));
    wait_idle();
  endtask

  task automatic test_extremes();
    // With one point in the store, the opposite corner gives the largest distance.
    send_request(CMD_LOAD,  coord_t'(32767),  coord_t'(32767),  coord_t'(32767));
    send_request(CMD_QUERY, coord_t'(-32768), coord_t'(-32768), coord_t'(-32768));
    send_request(CMD_LOAD,  coord_t'(-32768), coord_t'(-32768), coord_t'(-32768));
    send_request(CMD_LOAD,  coord_t'(0),      coord_t'(0),      coord_t'(0));
    send_request(CMD_LOAD,  coord_t'(-32768), coord_t'(32767),  coord_t'(-1));
    send_request(CMD_LOAD,  coord_t'(0),      coord_t'(0),      coord_t'(0));
    send_request(CMD_LOAD,  coord_t'(256),    coord_t'(0),      coord_t'(0));
    send_request(CMD_QUERY, coord_t'(-32768), coord_t'(-32768), coord_t'(-32768));
    send_request(CMD_QUERY, coord_t'(32767),  coord_t'(32767),  coord_t'(32767));
    // Two identical points at the origin: the earlier one must win.
    send_request(CMD_QUERY, coord_t'(0),      coord_t'(0),      coord_t'(0));
    send_request(CMD_QUERY, coord_t'(1),      coord_t'(1),      coord_t'(1));
    // Equally far from the origin and from the point on the x axis.
    send_request(CMD_QUERY, coord_t'(128),    coord_t'(128),    coord_t'(0));
    send_request(CMD_QUERY, coord_t'(-32768), coord_t'(32767),  coord_t'(-2));
    send_request(CMD_QUERY, coord_t'(32767),  coord_t'(-32768), coord_t'(32767));
    wait_idle();
  endtask

  task automatic test_random_mix();
    coord_t      x;
    coord_t      y;
    coord_t      z;
    int unsigned k;
    for (int n = 0; n < 520; n++) begin
      calm = (n >= 160 && n < 260);
      k = $urandom_range(99);
      x = rand_coord();
      y = rand_coord();
      z = rand_coord();
      if ($urandom_range(1) == 0) begin
        if (k < 15) begin
          pick_stored(x, y, z);
        end else if (k < 25) begin
          x = extreme_coord();
          y = extreme_coord();
          z = extreme_coord();
        end
        send_request(CMD_LOAD, x, y, z);
      end else begin
        if (k < 40) begin
          pick_stored(x, y, z);
          x = coord_t'(x + $urandom_range(8) - 4);
          y = coord_t'(y + $urandom_range(8) - 4);
          z = coord_t'(z + $urandom_range(8) - 4);
        end else if (k < 50) begin
          pick_stored(x, y, z);
        end
        send_request(CMD_QUERY, x, y, z);
      end
    end
    calm = 1'b0;
    wait_idle();
  endtask

  task automatic test_backpressure();
    @(posedge clk);
    hold_cycles = 400;
    @(negedge clk);
    for (int n = 0; n < 40; n++) begin
      send_request(($urandom_range(3) == 0) ? CMD_QUERY : CMD_LOAD,
                   rand_coord(), rand_coord(), rand_coord());
    end
    wait_idle();
  endtask

  // Result sink with random stalls and the long hold-off used for pressure.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready = 1'b0;
        hold_cycles--;
      end else begin
        m_tready = calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[OUT_FIELD_W-1:0]);
      if (pending_results.size() == 0) begin
        $error("unexpected result: nearest_index %0d nearest_distance %0d status %0d",
               got.idx, got.distance, got.status);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (got.idx !== want.idx) begin
          $error("nearest_index: expected %0d, got %0d", want.idx, got.idx);
          failures++;
        end
        if (got.distance !== want.distance) begin
          $error("nearest_distance: expected %0d, got %0d", want.distance, got.distance);
          failures++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          failures++;
        end
      end
    end
  end

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_store();
    test_extremes();
    test_random_mix();
    test_backpressure();

    // A stray result would come out within one full scan.
    repeat (STORE_DEPTH + 20) @(posedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- nearest_point_search_3d_top.f -----
sv/npsd_pkg.sv
sv/npsd_axis_cell.sv
sv/npsd_min_track.sv
sv/nearest_point_search_3d_top.sv
test/tb_top.sv
